// File: src/cmbta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbta_pkg
// Shared types, constants and face selection for the cube map tap addresser.
// ----------------------------------------------------------------------------
package cmbta_pkg;

  localparam int SIZE_W        = 11;
  localparam int MAX_FACE_SIZE = 1024;
  localparam int RESET_SIZE    = 256;
  localparam int NUM_W         = 28;   // (s+m)*size
  localparam int REM_W         = 16;
  localparam int DIV_BITS      = 27;   // quotient of n*2^15/m
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } dir_t;

  typedef struct packed {
    logic [2:0]  tap_face;
    logic [9:0]  tap_x;
    logic [9:0]  tap_y;
    logic [16:0] tap_weight;
    logic        last_tap;
  } tap_t;

  // side information that follows one tap pass down the pipeline
  typedef struct packed {
    logic [2:0]        face;
    logic [1:0]        k;
    logic [SIZE_W-1:0] size;
  } pass_t;

  typedef struct packed {
    logic [2:0]         face;
    logic signed [17:0] su;
    logic signed [17:0] sv;
    logic [16:0]        m;
  } face_sel_t;

  // major axis wins, ties go to x then y; zero vector maps to -x center
  function automatic face_sel_t pick_face(logic signed [17:0] x, logic signed [17:0] y,
                                          logic signed [17:0] z);
    face_sel_t   r;
    logic [17:0] ax;
    logic [17:0] ay;
    logic [17:0] az;
    ax = x[17] ? 18'(-x) : 18'(x);
    ay = y[17] ? 18'(-y) : 18'(y);
    az = z[17] ? 18'(-z) : 18'(z);
    r  = '0;
    if (ax == 18'd0 && ay == 18'd0 && az == 18'd0) begin
      r.face = FACE_NX;
      r.m    = 17'd1;
    end else if (ax >= ay && ax >= az) begin
      r.m = ax[16:0];
      if (x > 18'sd0) begin
        r.face = FACE_PX; r.su = -z; r.sv = -y;
      end else begin
        r.face = FACE_NX; r.su = z;  r.sv = -y;
      end
    end else if (ay >= az) begin
      r.m = ay[16:0];
      if (y > 18'sd0) begin
        r.face = FACE_PY; r.su = x; r.sv = z;
      end else begin
        r.face = FACE_NY; r.su = x; r.sv = -z;
      end
    end else begin
      r.m = az[16:0];
      if (z > 18'sd0) begin
        r.face = FACE_PZ; r.su = x;  r.sv = -y;
      end else begin
        r.face = FACE_NZ; r.su = -x; r.sv = -y;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/cmbta_face.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbta_face
// Two stages: major axis face pick, then scaling of the minor components by
// the face size into the numerators of the texel position.
// ----------------------------------------------------------------------------
module cmbta_face (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire cmbta_pkg::dir_t            dir_i,
  input  wire logic [1:0]                 k_i,
  input  wire logic [cmbta_pkg::SIZE_W-1:0] size_i,
  output logic                            valid_o,
  output cmbta_pkg::pass_t                pass_o,
  output logic [16:0]                     m_o,
  output logic [cmbta_pkg::NUM_W-1:0]     num_x_o,
  output logic [cmbta_pkg::NUM_W-1:0]     num_y_o
);
  import cmbta_pkg::*;

  logic              s1_valid_q;
  face_sel_t         s1_sel_q;
  face_sel_t         s1_sel_d;
  pass_t             s1_pass_q;
  logic              s2_valid_q;
  pass_t             s2_pass_q;
  logic [16:0]       s2_m_q;
  logic [NUM_W-1:0]  s2_nx_q;
  logic [NUM_W-1:0]  s2_ny_q;
  logic signed [18:0] sum_x;
  logic signed [18:0] sum_y;

  assign s1_sel_d = pick_face(18'(dir_i.dir_x), 18'(dir_i.dir_y), 18'(dir_i.dir_z));

  // s + m is never negative on the chosen face
  assign sum_x = 19'(s1_sel_q.su) + $signed({2'b00, s1_sel_q.m});
  assign sum_y = 19'(s1_sel_q.sv) + $signed({2'b00, s1_sel_q.m});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sel_q       <= s1_sel_d;
    s1_pass_q.face <= s1_sel_d.face;
    s1_pass_q.k    <= k_i;
    s1_pass_q.size <= size_i;
    s2_pass_q      <= s1_pass_q;
    s2_m_q         <= s1_sel_q.m;
    s2_nx_q        <= NUM_W'(sum_x[16:0]) * NUM_W'(s1_pass_q.size);
    s2_ny_q        <= NUM_W'(sum_y[16:0]) * NUM_W'(s1_pass_q.size);
  end

  assign valid_o = s2_valid_q;
  assign pass_o  = s2_pass_q;
  assign m_o     = s2_m_q;
  assign num_x_o = s2_nx_q;
  assign num_y_o = s2_ny_q;

endmodule
`default_nettype wire

// File: src/cmbta_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbta_div
// Pipelined restoring divider, two lanes sharing one divisor:
// q = floor(num * 2^15 / m), three quotient bits per stage.
// ----------------------------------------------------------------------------
module cmbta_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire cmbta_pkg::pass_t            pass_i,
  input  wire logic [16:0]                 m_i,
  input  wire logic [cmbta_pkg::NUM_W-1:0] num_x_i,
  input  wire logic [cmbta_pkg::NUM_W-1:0] num_y_i,
  output logic                             valid_o,
  output cmbta_pkg::pass_t                 pass_o,
  output logic [cmbta_pkg::DIV_BITS-1:0]   q_x_o,
  output logic [cmbta_pkg::DIV_BITS-1:0]   q_y_o
);
  import cmbta_pkg::*;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] bits;  // dividend bits still to come, quotient shifts in
  } div_lane_t;

  function automatic div_lane_t div_steps(div_lane_t l, logic [16:0] m);
    div_lane_t   r;
    logic [16:0] rr;
    r = l;
    for (int i = 0; i < DIV_PER_STAGE; i++) begin
      rr = {r.rem, r.bits[DIV_BITS-1]};
      if (rr >= m) begin
        rr     = rr - m;
        r.bits = {r.bits[DIV_BITS-2:0], 1'b1};
      end else begin
        r.bits = {r.bits[DIV_BITS-2:0], 1'b0};
      end
      r.rem = rr[REM_W-1:0];
    end
    return r;
  endfunction

  logic        valid_q [DIV_STAGES];
  pass_t       pass_q  [DIV_STAGES];
  logic [16:0] m_q     [DIV_STAGES];
  div_lane_t   lx_q    [DIV_STAGES];
  div_lane_t   ly_q    [DIV_STAGES];
  div_lane_t   lx0;
  div_lane_t   ly0;

  // top dividend bits are already below m since the quotient fits DIV_BITS
  assign lx0.rem  = num_x_i[NUM_W-1 -: REM_W];
  assign lx0.bits = {num_x_i[NUM_W-REM_W-1:0], 15'd0};
  assign ly0.rem  = num_y_i[NUM_W-1 -: REM_W];
  assign ly0.bits = {num_y_i[NUM_W-REM_W-1:0], 15'd0};

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        pass_q[s] <= pass_i;
        m_q[s]    <= m_i;
        lx_q[s]   <= div_steps(lx0, m_i);
        ly_q[s]   <= div_steps(ly0, m_i);
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else begin
          valid_q[s] <= valid_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        pass_q[s] <= pass_q[s-1];
        m_q[s]    <= m_q[s-1];
        lx_q[s]   <= div_steps(lx_q[s-1], m_q[s-1]);
        ly_q[s]   <= div_steps(ly_q[s-1], m_q[s-1]);
      end
    end
  end

  assign valid_o = valid_q[DIV_STAGES-1];
  assign pass_o  = pass_q[DIV_STAGES-1];
  assign q_x_o   = lx_q[DIV_STAGES-1].bits;
  assign q_y_o   = ly_q[DIV_STAGES-1].bits;

endmodule
`default_nettype wire

// File: src/cmbta_tap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmbta_tap
// Per tap: texel and weight factors, then seam resolution onto the
// neighboring face with the weight product, then weight rounding.
// ----------------------------------------------------------------------------
module cmbta_tap (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire cmbta_pkg::pass_t              pass_i,
  input  wire logic [cmbta_pkg::DIV_BITS-1:0] q_x_i,
  input  wire logic [cmbta_pkg::DIV_BITS-1:0] q_y_i,
  output logic                               tap_valid_o,
  output cmbta_pkg::tap_t                    tap_o
);
  import cmbta_pkg::*;

  // off-face taps land one texel past an edge, so the re-projected
  // coordinate is either an edge texel or a mirrored/copied row
  function automatic logic [9:0] edge_texel(logic signed [17:0] s, logic [SIZE_W-1:0] size);
    logic signed [17:0] ss;
    logic signed [17:0] h;
    logic [9:0]         r;
    ss = {7'd0, size};
    h  = s + ss - 18'sd1;
    if (s >= ss) begin
      r = 10'(size - 11'd1);
    end else if (s <= -ss) begin
      r = 10'd0;
    end else begin
      r = h[10:1];
    end
    return r;
  endfunction

  // stage 1
  logic               t1_valid_q;
  pass_t              t1_pass_q;
  logic signed [11:0] t1_tx_q;
  logic signed [11:0] t1_ty_q;
  logic [16:0]        t1_wx_q;
  logic [16:0]        t1_wy_q;
  logic signed [27:0] px;
  logic signed [27:0] py;
  logic signed [11:0] tx_d;
  logic signed [11:0] ty_d;
  logic [16:0]        wx_d;
  logic [16:0]        wy_d;

  assign px   = $signed({1'b0, q_x_i}) - 28'sd32768;
  assign py   = $signed({1'b0, q_y_i}) - 28'sd32768;
  assign tx_d = px[27:16] + $signed({11'd0, pass_i.k[0]});
  assign ty_d = py[27:16] + $signed({11'd0, pass_i.k[1]});
  assign wx_d = pass_i.k[0] ? {1'b0, px[15:0]} : 17'd65536 - {1'b0, px[15:0]};
  assign wy_d = pass_i.k[1] ? {1'b0, py[15:0]} : 17'd65536 - {1'b0, py[15:0]};

  always_ff @(posedge clk_i) begin
    t1_pass_q <= pass_i;
    t1_tx_q   <= tx_d;
    t1_ty_q   <= ty_d;
    t1_wx_q   <= wx_d;
    t1_wy_q   <= wy_d;
  end

  // stage 2
  logic               t2_valid_q;
  logic [33:0]        t2_prod_q;
  logic [2:0]         t2_face_q;
  logic [9:0]         t2_x_q;
  logic [9:0]         t2_y_q;
  logic               t2_last_q;
  logic signed [13:0] size_s;
  logic signed [13:0] aa;
  logic signed [13:0] bb;
  logic signed [17:0] vx;
  logic signed [17:0] vy;
  logic signed [17:0] vz;
  logic signed [17:0] sz;
  logic               on_face;
  face_sel_t          sel;

  assign size_s  = {3'd0, t1_pass_q.size};
  assign sz      = {7'd0, t1_pass_q.size};
  assign aa      = {t1_tx_q[11], t1_tx_q, 1'b1} - size_s;
  assign bb      = {t1_ty_q[11], t1_ty_q, 1'b1} - size_s;
  assign on_face = !t1_tx_q[11] && !t1_ty_q[11] &&
                   ({{2{t1_tx_q[11]}}, t1_tx_q} < size_s) &&
                   ({{2{t1_ty_q[11]}}, t1_ty_q} < size_s);

  // texel center back to a direction on its own face
  always_comb begin
    case (t1_pass_q.face)
      FACE_PX: begin vx = sz;        vy = -18'(bb); vz = -18'(aa); end
      FACE_NX: begin vx = -sz;       vy = -18'(bb); vz = 18'(aa);  end
      FACE_PY: begin vx = 18'(aa);   vy = sz;       vz = 18'(bb);  end
      FACE_NY: begin vx = 18'(aa);   vy = -sz;      vz = -18'(bb); end
      FACE_PZ: begin vx = 18'(aa);   vy = -18'(bb); vz = sz;       end
      default: begin vx = -18'(aa);  vy = -18'(bb); vz = -sz;      end
    endcase
  end

  assign sel = pick_face(vx, vy, vz);

  always_ff @(posedge clk_i) begin
    t2_prod_q <= 34'(t1_wx_q) * 34'(t1_wy_q);
    t2_last_q <= (t1_pass_q.k == 2'd3);
    if (on_face) begin
      t2_face_q <= t1_pass_q.face;
      t2_x_q    <= t1_tx_q[9:0];
      t2_y_q    <= t1_ty_q[9:0];
    end else begin
      t2_face_q <= sel.face;
      t2_x_q    <= edge_texel(sel.su, t1_pass_q.size);
      t2_y_q    <= edge_texel(sel.sv, t1_pass_q.size);
    end
  end

  // stage 3: output register
  logic  t3_valid_q;
  tap_t  t3_tap_q;
  logic [33:0] prod_rnd;

  assign prod_rnd = t2_prod_q + 34'd32768;

  always_ff @(posedge clk_i) begin
    t3_tap_q.tap_face   <= t2_face_q;
    t3_tap_q.tap_x      <= t2_x_q;
    t3_tap_q.tap_y      <= t2_y_q;
    t3_tap_q.tap_weight <= prod_rnd[32:16];
    t3_tap_q.last_tap   <= t2_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      t3_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= valid_i;
      t2_valid_q <= t1_valid_q;
      t3_valid_q <= t2_valid_q;
    end
  end

  assign tap_valid_o = t3_valid_q;
  assign tap_o       = t3_tap_q;

endmodule
`default_nettype wire

// File: src/cube_map_bilinear_tap_address.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cube_map_bilinear_tap_address
// Cube map face selection and four bilinear tap addresses per direction,
// with taps past a face edge moved onto the neighboring face.
// ----------------------------------------------------------------------------
// A direction is taken when start is high and busy low. Each direction
// yields four taps, one per cycle on consecutive cycles, in the order
// (x0,y0), (x0+1,y0), (x0,y0+1), (x0+1,y0+1), marked by tap_valid_o; the
// fourth has last_tap set. Every tap is a separate pass through the
// pipeline, so busy stays high after a transaction until its last tap
// pass starts, and only then is a new direction taken. The output has no
// backpressure: the receiver must take each tap in the cycle it is shown.
// face_size is written through the cfg channel, which is always ready;
// the user must write it only while no directions are in flight, as the
// block itself does not enforce this.
module cube_map_bilinear_tap_address (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire cmbta_pkg::dir_t               dir_i,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cmbta_pkg::SIZE_W-1:0]  cfg_data_i,
  output logic                               tap_valid_o,
  output cmbta_pkg::tap_t                    tap_o
);
  import cmbta_pkg::*;

  logic [SIZE_W-1:0] face_size_q;
  logic [SIZE_W-1:0] size_eff;
  logic              active_q;
  logic [1:0]        cnt_q;
  dir_t              dir_q;
  logic              accept;

  assign cfg_ready_o = 1'b1;
  assign busy        = active_q && (cnt_q != 2'd3);
  assign accept      = start && !busy;

  // zero acts as one, oversize clamps to the largest face
  assign size_eff = (face_size_q == '0) ? SIZE_W'(1) :
                    (face_size_q > SIZE_W'(MAX_FACE_SIZE)) ? SIZE_W'(MAX_FACE_SIZE) :
                    face_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= SIZE_W'(RESET_SIZE);
      active_q    <= 1'b0;
      cnt_q       <= 2'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        face_size_q <= cfg_data_i;
      end
      if (accept) begin
        active_q <= 1'b1;
        cnt_q    <= 2'd0;
      end else if (active_q) begin
        if (cnt_q == 2'd3) begin
          active_q <= 1'b0;
        end
        cnt_q <= cnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dir_q <= dir_i;
    end
  end

  logic                f_valid;
  pass_t               f_pass;
  logic [16:0]         f_m;
  logic [NUM_W-1:0]    f_nx;
  logic [NUM_W-1:0]    f_ny;
  logic                d_valid;
  pass_t               d_pass;
  logic [DIV_BITS-1:0] d_qx;
  logic [DIV_BITS-1:0] d_qy;

  cmbta_face u_face (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (active_q),
    .dir_i   (dir_q),
    .k_i     (cnt_q),
    .size_i  (size_eff),
    .valid_o (f_valid),
    .pass_o  (f_pass),
    .m_o     (f_m),
    .num_x_o (f_nx),
    .num_y_o (f_ny)
  );

  cmbta_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .pass_i  (f_pass),
    .m_i     (f_m),
    .num_x_i (f_nx),
    .num_y_i (f_ny),
    .valid_o (d_valid),
    .pass_o  (d_pass),
    .q_x_o   (d_qx),
    .q_y_o   (d_qy)
  );

  cmbta_tap u_tap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (d_valid),
    .pass_i      (d_pass),
    .q_x_i       (d_qx),
    .q_y_i       (d_qy),
    .tap_valid_o (tap_valid_o),
    .tap_o       (tap_o)
  );

  // a transaction keeps the block busy while its taps are issued
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy low right after a transaction");

  // taps of one direction leave back to back
  a_taps_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_valid_o && !tap_o.last_tap |=> tap_valid_o)
    else $error("tap sequence broken before last tap");

  a_weight_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_valid_o |-> tap_o.tap_weight <= 17'd65536)
    else $error("tap weight above one");

  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_valid_o |-> tap_o.tap_face <= FACE_NZ)
    else $error("tap face code out of range");

endmodule
`default_nettype wire

// File: bench/tb_cube_map_bilinear_tap_address.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cube_map_bilinear_tap_address
// Drives lookup directions and face sizes into the tap addresser, predicts
// the four bilinear taps of each direction and checks every tap in order.
// ----------------------------------------------------------------------------
module tb_cube_map_bilinear_tap_address;
  import cmbta_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  dir_t        dir_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i;
  logic        tap_valid_o;
  tap_t        tap_o;

  tap_t   tap_queue[$];
  int     errors;
  longint face_edge;
  bit     idle_on;

  cube_map_bilinear_tap_address dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .dir_i(dir_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .tap_valid_o(tap_valid_o), .tap_o(tap_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  // major axis selection: face, minor components and major magnitude
  task automatic select_face(input longint x, y, z, output logic [2:0] face,
                             output longint su, sv, m);
    longint ax, ay, az;
    ax = abs64(x); ay = abs64(y); az = abs64(z);
    if (ax == 0 && ay == 0 && az == 0) begin
      face = FACE_NX; su = 0; sv = 0; m = 1;
    end else if (ax >= ay && ax >= az) begin
      m = ax;
      if (x > 0) begin face = FACE_PX; su = -z; sv = -y; end
      else begin face = FACE_NX; su = z; sv = -y; end
    end else if (ay >= az) begin
      m = ay;
      if (y > 0) begin face = FACE_PY; su = x; sv = z; end
      else begin face = FACE_NY; su = x; sv = -z; end
    end else begin
      m = az;
      if (z > 0) begin face = FACE_PZ; su = x; sv = -y; end
      else begin face = FACE_NZ; su = -x; sv = -y; end
    end
  endtask

  function automatic longint edge_clamp(longint s, longint m, longint n);
    longint t;
    t = ((s + m) * n) / (2 * m);
    if (t < 0) t = 0;
    if (t > n - 1) t = n - 1;
    return t;
  endfunction

  task automatic predict_taps(input dir_t d);
    longint     n, su, sv, m, px, py, x0, y0, fx, fy, tx, ty, a, b, vx, vy, vz;
    longint     wx[2], wy[2], ox, oy, s2, t2, m2;
    logic [2:0] face, nf;
    tap_t       t;
    n = face_edge;
    if (n < 1) n = 1;
    if (n > MAX_FACE_SIZE) n = MAX_FACE_SIZE;
    select_face(d.dir_x, d.dir_y, d.dir_z, face, su, sv, m);
    px = fdiv(((su + m) * n - m) * 65536, 2 * m);
    py = fdiv(((sv + m) * n - m) * 65536, 2 * m);
    x0 = fdiv(px, 65536);
    y0 = fdiv(py, 65536);
    fx = px - x0 * 65536;
    fy = py - y0 * 65536;
    wx[0] = 65536 - fx; wx[1] = fx;
    wy[0] = 65536 - fy; wy[1] = fy;
    for (int k = 0; k < 4; k++) begin
      tx = x0 + (k & 1);
      ty = y0 + (k >> 1);
      if (tx >= 0 && ty >= 0 && tx < n && ty < n) begin
        nf = face; ox = tx; oy = ty;
      end else begin
        // off the face: back to a direction, then onto the owning face
        a = 2 * tx + 1 - n;
        b = 2 * ty + 1 - n;
        case (face)
          FACE_PX: begin vx = n;  vy = -b; vz = -a; end
          FACE_NX: begin vx = -n; vy = -b; vz = a;  end
          FACE_PY: begin vx = a;  vy = n;  vz = b;  end
          FACE_NY: begin vx = a;  vy = -n; vz = -b; end
          FACE_PZ: begin vx = a;  vy = -b; vz = n;  end
          default: begin vx = -a; vy = -b; vz = -n; end
        endcase
        select_face(vx, vy, vz, nf, s2, t2, m2);
        ox = edge_clamp(s2, m2, n);
        oy = edge_clamp(t2, m2, n);
      end
      t.tap_face   = nf;
      t.tap_x      = ox[9:0];
      t.tap_y      = oy[9:0];
      t.tap_weight = 17'((wx[k & 1] * wy[k >> 1] + 32768) >> 16);
      t.last_tap   = (k == 3);
      tap_queue = {tap_queue, t};
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && tap_valid_o) begin
      if (tap_queue.size() == 0) begin
        $display("%0t: unexpected tap %p", $time, tap_o);
        errors++;
      end else begin
        if (tap_o !== tap_queue[0]) begin
          $display("%0t: tap mismatch expected %p actual %p", $time, tap_queue[0], tap_o);
          errors++;
        end
        void'(tap_queue.pop_front());
      end
    end
  end

  // start stays high between back to back transactions and drops for a gap
  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  task automatic send_dir(input logic signed [15:0] x, y, z);
    dir_t d;
    d.dir_x = x; d.dir_y = y; d.dir_z = z;
    idle_gap();
    start <= 1'b1;
    dir_i <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_taps(d);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tap_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [10:0] n);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    face_edge = n;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_dir();
    logic signed [15:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 5))
        0: v[i] = 16'sh8000;
        1: v[i] = 16'sh7fff;
        2: v[i] = 16'($signed($urandom_range(0, 8)) - 4);
        default: v[i] = 16'($urandom);
      endcase
    end
    // make ties between the x and y magnitudes common
    if ($urandom_range(0, 4) == 0) v[1] = $urandom_range(0, 1) ? v[0] : -v[0];
    send_dir(v[0], v[1], v[2]);
  endtask

  task automatic test_directed();
    send_dir(0, 0, 0);
    send_dir(100, 0, 0);
    send_dir(-100, 0, 0);
    send_dir(0, 100, 0);
    send_dir(0, -100, 0);
    send_dir(0, 0, 100);
    send_dir(0, 0, -100);
    send_dir(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_dir(16'sh8000, 16'sh8000, 16'sh8000);
    send_dir(-5, 5, -5);
    send_dir(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_dir(1000, 999, -999);
    send_dir(16'sh8000, 16'sh7fff, 0);
    send_dir(7, 0, -7);
    send_dir(16'sh7fff, -16'sh7fff, 1);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) random_dir();
  endtask

  task automatic test_sizes();
    logic [10:0] sizes[6] = '{11'd1, 11'd2, 11'd1024, 11'd0, 11'd2047, 11'd3};
    foreach (sizes[i]) begin
      write_size(sizes[i]);
      test_directed();
      test_random(8);
    end
    write_size(11'($urandom_range(1, 1024)));
    test_random(20);
  endtask

  initial begin
    errors = 0; face_edge = RESET_SIZE; idle_on = 1'b1;
    start = 1'b0; dir_i = '0; cfg_valid_i = 1'b0; cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(40);
    drain();
    test_sizes();
    write_size(11'd256);
    idle_on = 1'b0;
    test_random(20);
    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
